FILE: rtl/cluster_task_dispatcher_unit_macros.svh
// assertion macros for the cluster task dispatcher
`ifndef CLUSTER_TASK_DISPATCHER_UNIT_MACROS_SVH
`define CLUSTER_TASK_DISPATCHER_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CTD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CTD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// shared constants, types and command structs of the cluster task dispatcher
// ----------------------------------------------------------------------------
`default_nettype none
package ctd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_CPU     = 64;
    localparam int MAX_SLOTS   = 64;

    localparam int CPU_W   = 7;
    localparam int QLIM_W  = 5;
    localparam int TICKS_W = 16;
    localparam int TCNT_W  = 32;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CPU   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'd1;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture the input item and clear tick statistics
        logic scan;       // examine the slot at the scan index
        logic admit;      // admit or reject the captured task
        logic fetch;      // read the queue head
        logic dispatch;   // start the head in the found free slot
        logic finish;     // publish the result and advance the tick counter
    } ctd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;  // scan index sits on the last slot
        logic queue_empty;
        logic head_fits;  // head cpu need fits and a free slot exists
    } ctd_status_t;

endpackage
`default_nettype wire

FILE: rtl/ctd_ram.sv
// ----------------------------------------------------------------------------
// ctd_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/ctd_ctrl.sv
// ----------------------------------------------------------------------------
// ctd_ctrl
// tick sequencer: retire scan, admit, dispatch loop, result handoff
// ----------------------------------------------------------------------------
`default_nettype none
module ctd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire ctd_pkg::ctd_status_t status,
    output ctd_pkg::ctd_cmd_t        cmd
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_ADMIT = 7'b0000100,
        ST_FETCH = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_DISP  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // the result register frees once taken, so a new item can start meanwhile
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_ADMIT;
                end
            end
            ST_ADMIT: begin
                cmd.admit  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                // issue the head read; the ram read is registered, so data is valid in the cycle after
                if (status.queue_empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DISP;
            end
            ST_DISP: begin
                if (status.head_fits) begin
                    cmd.dispatch = 1'b1;
                    state_next   = ST_FETCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ctd_datapath.sv
// ----------------------------------------------------------------------------
// ctd_datapath
// slot table, wait queue, cpu accounting and per-tick statistics
// ----------------------------------------------------------------------------
`default_nettype none
module ctd_datapath #(
    parameter int QUEUE_DEPTH = ctd_pkg::QUEUE_DEPTH,
    parameter int MAX_CPU     = ctd_pkg::MAX_CPU,
    parameter int MAX_SLOTS   = ctd_pkg::MAX_SLOTS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [ctd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ctd_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            s_task_valid,
    input  wire logic [ctd_pkg::CPU_W-1:0]       s_task_cpu,
    input  wire logic [ctd_pkg::TICKS_W-1:0]     s_task_ticks,
    input  wire ctd_pkg::ctd_cmd_t               cmd,
    output ctd_pkg::ctd_status_t                 status,
    output logic                                 m_task_appeared,
    output logic                                 m_task_rejected,
    output logic [6:0]                           m_completed_count,
    output logic [4:0]                           m_dispatched_count,
    output logic [6:0]                           m_busy_cpu,
    output logic                                 m_idle_tick,
    output logic [4:0]                           m_queued_tasks,
    output logic [6:0]                           m_running_tasks
);
    localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SA_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SC_W  = $clog2(MAX_SLOTS + 1);
    localparam int AC_W  = $clog2(MAX_CPU + 1) + 1;
    localparam int TC_W  = ctd_pkg::TCNT_W;
    localparam int TK_W  = ctd_pkg::TICKS_W;
    localparam int CP_W  = ctd_pkg::CPU_W;
    localparam int QE_W  = CP_W + TK_W;
    localparam int SE_W  = TC_W + TK_W + CP_W;
    localparam int QLW = ctd_pkg::QLIM_W;
    localparam logic [CP_W-1:0]   MAX_CPU_C = CP_W'(MAX_CPU);
    localparam logic [QLW-1:0]    QDEP_C    = QLW'(QUEUE_DEPTH);

    logic [CP_W-1:0]  total_cpu_reg;
    logic [QLW-1:0]   queue_limit_reg;
    logic [TC_W-1:0]  tick_reg;
    logic [QA_W-1:0]  head_reg;
    logic [QC_W-1:0]  count_reg;
    logic [MAX_SLOTS-1:0] busy_reg;
    logic [AC_W-1:0]  active_reg;
    logic [SA_W-1:0]  scan_reg;
    logic [SC_W-1:0]  running_reg;

    logic             in_valid_reg;
    logic [CP_W-1:0]  in_cpu_reg;
    logic [TK_W-1:0]  in_ticks_reg;
    logic             rejected_reg;
    logic [6:0]       completed_reg;
    logic [4:0]       dispatched_reg;

    // slot table ram: start, length, cpu
    logic [SE_W-1:0]  slot_rdata;
    logic [SE_W-1:0]  slot_wdata;
    logic [SA_W-1:0]  slot_raddr;
    logic [SA_W-1:0]  free_slot;
    logic             free_any;
    logic             scan_valid_reg;
    logic [SA_W-1:0]  scan_idx_reg;

    logic [QE_W-1:0]  q_rdata;
    logic [QA_W-1:0]  q_tail;
    logic             q_we;
    logic             admit_ok;

    logic [TC_W-1:0]  s_start;
    logic [TK_W-1:0]  s_len;
    logic [CP_W-1:0]  s_cpu;
    logic             retire;
    logic [CP_W-1:0]  h_cpu;
    logic [TK_W-1:0]  h_ticks;
    logic [AC_W-1:0]  head_sum;

    assign {s_start, s_len, s_cpu} = slot_rdata;
    assign {h_cpu, h_ticks}        = q_rdata;
    assign slot_raddr = scan_reg;
    assign slot_wdata = {tick_reg, h_ticks, h_cpu};

    ctd_ram #(.WIDTH(SE_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (cmd.dispatch),
        .waddr (free_slot),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign q_tail = QA_W'((QC_W + QA_W + 1)'(head_reg) + (QC_W + QA_W + 1)'(count_reg)
                    - ((QC_W + QA_W + 1)'(head_reg) + (QC_W + QA_W + 1)'(count_reg)
                       >= (QC_W + QA_W + 1)'(QUEUE_DEPTH) ? (QC_W + QA_W + 1)'(QUEUE_DEPTH)
                                                         : '0));
    assign admit_ok = ((QLW+1)'(count_reg) < (QLW+1)'(queue_limit_reg))
                      && (count_reg < QC_W'(QUEUE_DEPTH))
                      && (in_cpu_reg <= total_cpu_reg);
    assign q_we = cmd.admit && in_valid_reg && admit_ok;

    ctd_ram #(.WIDTH(QE_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_tail),
        .wdata ({in_cpu_reg, in_ticks_reg}),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // lowest free slot, priority over the busy vector
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_slot = SA_W'(i);
                free_any  = 1'b1;
            end
        end
    end

    assign retire   = scan_valid_reg && busy_reg[scan_idx_reg]
                      && ((tick_reg - s_start) == TC_W'(s_len));
    assign head_sum = active_reg + AC_W'(h_cpu);

    assign status.scan_last   = (scan_reg == SA_W'(MAX_SLOTS - 1));
    assign status.queue_empty = (count_reg == '0);
    assign status.head_fits   = free_any && (head_sum <= AC_W'(total_cpu_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_cpu_reg   <= MAX_CPU_C;
            queue_limit_reg <= QDEP_C;
            tick_reg        <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            busy_reg        <= '0;
            active_reg      <= '0;
            scan_reg        <= '0;
            scan_valid_reg  <= 1'b0;
            running_reg     <= '0;
        end else begin
            if (cfg_we && cfg_index == ctd_pkg::REG_TOTAL_CPU) begin
                total_cpu_reg <= (cfg_data > MAX_CPU_C) ? MAX_CPU_C : cfg_data;
            end
            if (cfg_we && cfg_index == ctd_pkg::REG_QUEUE_LIMIT) begin
                queue_limit_reg <= (cfg_data[QLW-1:0] > QDEP_C) ? QDEP_C : cfg_data[QLW-1:0];
            end
            // read data of slot scan_idx arrives in the cycle after the address
            scan_valid_reg <= cmd.scan;
            scan_idx_reg   <= scan_reg;
            if (cmd.scan) begin
                scan_reg <= status.scan_last ? '0 : scan_reg + 1'b1;
            end
            if (retire) begin
                busy_reg[scan_idx_reg] <= 1'b0;
                active_reg  <= (active_reg >= AC_W'(s_cpu)) ? active_reg - AC_W'(s_cpu) : '0;
                running_reg <= running_reg - 1'b1;
            end
            if (q_we) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.dispatch) begin
                busy_reg[free_slot] <= 1'b1;
                active_reg  <= head_sum;
                running_reg <= running_reg + 1'b1;
                head_reg    <= (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_reg   <= count_reg - 1'b1;
            end
            if (cmd.finish) begin
                tick_reg <= tick_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_valid_reg   <= s_task_valid;
            in_cpu_reg     <= s_task_cpu;
            in_ticks_reg   <= s_task_ticks;
            rejected_reg   <= 1'b0;
            completed_reg  <= '0;
            dispatched_reg <= '0;
        end
        if (retire) begin
            completed_reg <= completed_reg + 1'b1;
        end
        if (cmd.admit && in_valid_reg && !admit_ok) begin
            rejected_reg <= 1'b1;
        end
        if (cmd.dispatch) begin
            dispatched_reg <= dispatched_reg + 1'b1;
        end
        if (cmd.finish) begin
            m_task_appeared    <= in_valid_reg;
            m_task_rejected    <= rejected_reg;
            m_completed_count  <= completed_reg;
            m_dispatched_count <= dispatched_reg;
            m_busy_cpu         <= 7'(active_reg);
            m_idle_tick        <= (active_reg == '0);
            m_queued_tasks     <= 5'(count_reg);
            m_running_tasks    <= 7'(running_reg);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/cluster_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// cluster_task_dispatcher_unit
// tick-driven cluster scheduler with a bounded wait queue and slot table
// ----------------------------------------------------------------------------
// Each input item is one tick, optionally carrying a new task (cpu need and
// duration). Per tick the block retires finished tasks, admits or rejects the
// new one, dispatches queue heads into free slots, then emits one result item
// with the tick statistics on the m_ channel.
// The retire scan reads one slot entry per cycle; each dispatch then takes a
// head read and a start. One item is processed at a time; the next is taken
// once a result is registered, also while that result waits, but a finished
// tick holds until the receiver takes the previous one.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; issue them
// only while the block is idle. Synchronous reset aresetn clears the queue,
// the slot table busy bits, cpu use and the tick counter; total_cpu returns
// to 64 and queue_limit to 16.
// ----------------------------------------------------------------------------
`default_nettype none
module cluster_task_dispatcher_unit #(
    parameter int QUEUE_DEPTH = ctd_pkg::QUEUE_DEPTH,
    parameter int MAX_CPU     = ctd_pkg::MAX_CPU,
    parameter int MAX_SLOTS   = ctd_pkg::MAX_SLOTS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ctd_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_task_valid,
    input  wire logic [6:0]                     s_task_cpu,
    input  wire logic [15:0]                    s_task_ticks,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_task_appeared,
    output logic                                m_task_rejected,
    output logic [6:0]                          m_completed_count,
    output logic [4:0]                          m_dispatched_count,
    output logic [6:0]                          m_busy_cpu,
    output logic                                m_idle_tick,
    output logic [4:0]                          m_queued_tasks,
    output logic [6:0]                          m_running_tasks
);
    ctd_pkg::ctd_cmd_t    cmd;
    ctd_pkg::ctd_status_t status;

    ctd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ctd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_CPU     (MAX_CPU),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_task_valid       (s_task_valid),
        .s_task_cpu         (s_task_cpu),
        .s_task_ticks       (s_task_ticks),
        .cmd                (cmd),
        .status             (status),
        .m_task_appeared    (m_task_appeared),
        .m_task_rejected    (m_task_rejected),
        .m_completed_count  (m_completed_count),
        .m_dispatched_count (m_dispatched_count),
        .m_busy_cpu         (m_busy_cpu),
        .m_idle_tick        (m_idle_tick),
        .m_queued_tasks     (m_queued_tasks),
        .m_running_tasks    (m_running_tasks)
    );
endmodule
`default_nettype wire

FILE: rtl/ctd_checker.sv
// ----------------------------------------------------------------------------
// ctd_checker
// port-level checks of the cluster task dispatcher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "cluster_task_dispatcher_unit_macros.svh"
module ctd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_task_appeared,
    input wire logic       m_task_rejected,
    input wire logic [6:0] m_busy_cpu,
    input wire logic       m_idle_tick
);
    // a rejection only ever goes with an arrival
    `CTD_ASSERT_IMPL(a_rej_needs_task, aclk, aresetn, m_valid && m_task_rejected, m_task_appeared, "rejected without task")
    // idle flag agrees with the busy cpu count
    `CTD_ASSERT_IMPL(a_idle_flag, aclk, aresetn, m_valid, m_idle_tick == (m_busy_cpu == 7'd0), "idle flag mismatch")
    // an accepted item is never followed by a result in the very next cycle
    `CTD_ASSERT_NEXT(a_no_instant, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid, "result too early")
    // a stalled result stays
    `CTD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_busy_cpu), "result dropped")
endmodule

bind cluster_task_dispatcher_unit ctd_checker u_ctd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_task_appeared (m_task_appeared),
    .m_task_rejected (m_task_rejected),
    .m_busy_cpu      (m_busy_cpu),
    .m_idle_tick     (m_idle_tick)
);
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the cluster task dispatcher tick by tick against a local scheduler
// model; directed corner ticks, then random task streams under three
// handshake idling mixes and several cluster and queue-limit settings
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

    typedef struct packed {
        logic       arrive;
        logic [6:0] cpu;
        logic [15:0] ticks;
    } tick_in_t;

    typedef struct packed {
        logic       appeared;
        logic       rejected;
        logic [6:0] completed;
        logic [4:0] dispatched;
        logic [6:0] busy;
        logic       idle;
        logic [4:0] queued;
        logic [6:0] running;
    } tick_stats_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [ctd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ctd_pkg::CFG_W-1:0]     cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_task_valid = 1'b0;
    logic [6:0]  s_task_cpu = '0;
    logic [15:0] s_task_ticks = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_task_appeared, m_task_rejected, m_idle_tick;
    logic [6:0]  m_completed_count, m_busy_cpu, m_running_tasks;
    logic [4:0]  m_dispatched_count, m_queued_tasks;

    cluster_task_dispatcher_unit u_dut (.*);

    always #10 aclk = ~aclk;

    // scheduler model state
    int unsigned model_total, model_limit, tick_no, q_head, q_count, cpu_used;
    logic [6:0]  q_cpu [ctd_pkg::QUEUE_DEPTH];
    logic [15:0] q_ticks [ctd_pkg::QUEUE_DEPTH];
    bit          slot_on [ctd_pkg::MAX_SLOTS];
    int unsigned slot_t0 [ctd_pkg::MAX_SLOTS];
    int unsigned slot_len [ctd_pkg::MAX_SLOTS];
    int unsigned slot_need [ctd_pkg::MAX_SLOTS];

    tick_in_t    pending_ticks[$];
    tick_stats_t expected_stats[$];
    int          errors = 0;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    bit          sender_hold = 0;
    bit          in_taken = 0;

    function automatic tick_stats_t schedule_tick(tick_in_t t);
        tick_stats_t r;
        int s, f, n;
        r = '0;
        r.appeared = t.arrive;
        n = 0;
        for (s = 0; s < ctd_pkg::MAX_SLOTS; s++)
            if (slot_on[s] && (tick_no - slot_t0[s]) == slot_len[s]) begin
                slot_on[s] = 0;
                cpu_used = (cpu_used >= slot_need[s]) ? cpu_used - slot_need[s] : 0;
                n++;
            end
        r.completed = 7'(n);
        if (t.arrive) begin
            if (q_count < model_limit && t.cpu <= model_total) begin
                q_cpu[(q_head + q_count) % ctd_pkg::QUEUE_DEPTH] = t.cpu;
                q_ticks[(q_head + q_count) % ctd_pkg::QUEUE_DEPTH] = t.ticks;
                q_count++;
            end else begin
                r.rejected = 1'b1;
            end
        end
        n = 0;
        while (q_count > 0) begin
            if (cpu_used + q_cpu[q_head] > model_total) break;
            f = -1;
            for (s = 0; s < ctd_pkg::MAX_SLOTS; s++)
                if (!slot_on[s]) begin
                    f = s;
                    break;
                end
            if (f < 0) break;
            slot_on[f] = 1;
            slot_t0[f] = tick_no;
            slot_len[f] = q_ticks[q_head];
            slot_need[f] = q_cpu[q_head];
            cpu_used += q_cpu[q_head];
            q_head = (q_head + 1) % ctd_pkg::QUEUE_DEPTH;
            q_count--;
            n++;
        end
        r.dispatched = 5'(n);
        r.busy = 7'(cpu_used);
        r.idle = (cpu_used == 0);
        r.queued = 5'(q_count);
        n = 0;
        for (s = 0; s < ctd_pkg::MAX_SLOTS; s++) if (slot_on[s]) n++;
        r.running = 7'(n);
        tick_no++;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // input handshake seen at the rising edge
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
    end

    // driver
    always @(negedge aclk) begin
        if (in_taken) begin
            expected_stats = {expected_stats, schedule_tick(pending_ticks.pop_front())};
        end
        if (in_taken || !s_valid) begin
            if (pending_ticks.size() > 0 && !sender_hold && aresetn &&
                $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_task_valid <= pending_ticks[0].arrive;
                s_task_cpu <= pending_ticks[0].cpu;
                s_task_ticks <= pending_ticks[0].ticks;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge aclk) begin
        tick_stats_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                w = expected_stats.pop_front();
                if (m_task_appeared !== w.appeared)
                    report_mismatch("task_appeared", m_task_appeared, w.appeared);
                if (m_task_rejected !== w.rejected)
                    report_mismatch("task_rejected", m_task_rejected, w.rejected);
                if (m_completed_count !== w.completed)
                    report_mismatch("completed_count", m_completed_count, w.completed);
                if (m_dispatched_count !== w.dispatched)
                    report_mismatch("dispatched_count", m_dispatched_count, w.dispatched);
                if (m_busy_cpu !== w.busy)
                    report_mismatch("busy_cpu", m_busy_cpu, w.busy);
                if (m_idle_tick !== w.idle)
                    report_mismatch("idle_tick", m_idle_tick, w.idle);
                if (m_queued_tasks !== w.queued)
                    report_mismatch("queued_tasks", m_queued_tasks, w.queued);
                if (m_running_tasks !== w.running)
                    report_mismatch("running_tasks", m_running_tasks, w.running);
            end
        end
    end

    function automatic tick_in_t rand_tick();
        tick_in_t t;
        t.arrive = ($urandom_range(99) < 75);
        case ($urandom_range(9))
            0: t.cpu = 7'($urandom_range(127));
            1: t.cpu = 0;
            default: t.cpu = 7'($urandom_range(1, 24));
        endcase
        case ($urandom_range(9))
            0: t.ticks = 16'($urandom_range(65535));
            1: t.ticks = 16'(16'hffff - $urandom_range(3));
            default: t.ticks = 16'($urandom_range(1, 40));
        endcase
        return t;
    endfunction

    task automatic add_tick(logic a, int c, int k);
        tick_in_t t;
        t.arrive = a;
        t.cpu = 7'(c);
        t.ticks = 16'(k);
        pending_ticks = {pending_ticks, t};
    endtask

    task automatic drain();
        wait (pending_ticks.size() == 0 && !s_valid && expected_stats.size() == 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ctd_pkg::CFG_IDX_W-1:0] idx, int v);
        int m;
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[ctd_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        m = v & 'h7f;
        if (idx == ctd_pkg::REG_TOTAL_CPU)
            model_total = (m > ctd_pkg::MAX_CPU) ? ctd_pkg::MAX_CPU : m;
        else
            model_limit = ((v & 'h1f) > ctd_pkg::QUEUE_DEPTH) ? ctd_pkg::QUEUE_DEPTH
                                                               : (v & 'h1f);
    endtask

    task automatic random_phase(int n, int tot, int lim);
        drain();
        write_reg(ctd_pkg::REG_TOTAL_CPU, tot);
        write_reg(ctd_pkg::REG_QUEUE_LIMIT, lim);
        repeat (n) pending_ticks = {pending_ticks, rand_tick()};
    endtask

    initial begin
        model_total = ctd_pkg::MAX_CPU;
        model_limit = ctd_pkg::QUEUE_DEPTH;
        tick_no = 0; q_head = 0; q_count = 0; cpu_used = 0;
        foreach (slot_on[s]) slot_on[s] = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 23; recv_idle_pct = 71;

        // directed corners at reset settings
        add_tick(1'b0, 0, 0);
        add_tick(1'b1, 64, 1);
        add_tick(1'b1, 65, 3);
        add_tick(1'b1, 127, 16'hffff);
        add_tick(1'b1, 0, 2);
        add_tick(1'b1, 1, 16'hffff);
        add_tick(1'b1, 0, 0);
        add_tick(1'b1, 63, 5);
        add_tick(1'b1, 2, 1);
        add_tick(1'b0, 127, 16'hffff);
        for (int i = 0; i < 6; i++) add_tick(1'b0, 0, 0);
        // send more 40-cpu arrivals than the queue depth while the cluster is busy
        for (int i = 0; i < 18; i++) add_tick(1'b1, 40, 1);

        // zero queue limit and zero cpu total, oversized writes
        random_phase(8, 0, 0);
        random_phase(20, 127, 31);
        random_phase(20, 1, 1);
        // lowered limit and total while work is queued
        random_phase(10, 64, 16);
        drain();
        write_reg(ctd_pkg::REG_TOTAL_CPU, 8);
        write_reg(ctd_pkg::REG_QUEUE_LIMIT, 2);
        random_phase(0, 8, 2);
        repeat (20) pending_ticks = {pending_ticks, rand_tick()};

        random_phase(150, 64, 16);
        // sender holds back until every outstanding result has come
        wait (pending_ticks.size() < 75);
        sender_hold = 1;
        wait (!s_valid && expected_stats.size() == 0);
        sender_hold = 0;
        drain();
        send_idle_pct = 71; recv_idle_pct = 23;
        random_phase(150, 32, 5);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(150, 64, 16);
        drain();

        if (errors == 0) begin
            $display("cluster_task_dispatcher_unit test passed");
        end else begin
            $display("cluster_task_dispatcher_unit test failed");
        end
        $finish;
    end

    initial begin
        #(20ms);
        $display("cluster_task_dispatcher_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
